>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define XFCM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define XFCM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/xfcm_pkg.sv
package xfcm_pkg;

    localparam int unsigned FIN_COUNT = 4;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic signed [15:0] angle_t;
    typedef logic [14:0] limit_t;
    // sums of two angles plus the half-turn wrap and deadband difference
    typedef logic signed [17:0] wide_t;
    typedef logic [2:0] cmd_code_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cmd_code_t CMD_FINS    = 3'd0;
    localparam cmd_code_t CMD_SAFETY  = 3'd1;
    localparam cmd_code_t CMD_TIMEOUT = 3'd2;
    localparam cmd_code_t CMD_RESET   = 3'd3;
    localparam cmd_code_t CMD_DIRECT  = 3'd4;

    localparam cfg_index_t REG_HOME_FIN1  = 3'd0;
    localparam cfg_index_t REG_HOME_FIN2  = 3'd1;
    localparam cfg_index_t REG_HOME_FIN3  = 3'd2;
    localparam cfg_index_t REG_HOME_FIN4  = 3'd3;
    localparam cfg_index_t REG_LIMIT_FIN1 = 3'd4;
    localparam cfg_index_t REG_LIMIT_FIN2 = 3'd5;
    localparam cfg_index_t REG_LIMIT_FIN3 = 3'd6;
    localparam cfg_index_t REG_LIMIT_FIN4 = 3'd7;

    localparam wide_t HALF_TURN = 18'sd18000;
    localparam wide_t FULL_TURN = 18'sd36000;
    localparam wide_t DEADBAND  = 18'sd20;
    localparam limit_t LIMIT_RESET = 15'd18000;

    typedef struct packed {
        cmd_code_t    command;
        angle_t       req_top;
        angle_t       req_stbd;
        angle_t       req_bottom;
        angle_t       req_port;
        logic [3:0]   angle_valid;
        logic         enable_flag;
        logic [2:0]   fin_select;
        angle_t       position;
    } in_t;

    typedef struct packed {
        angle_t fin1_command;
        angle_t fin2_command;
        angle_t fin3_command;
        angle_t fin4_command;
        logic   select_error;
    } out_t;

endpackage

>>> rtl/xfcm_fin_lane.sv
module xfcm_fin_lane (
    input  xfcm_pkg::angle_t angle_a,
    input  xfcm_pkg::angle_t angle_b,
    input  xfcm_pkg::angle_t command,
    input  xfcm_pkg::limit_t limit,
    output xfcm_pkg::angle_t next_command
);

    xfcm_pkg::wide_t sum;
    xfcm_pkg::wide_t wrapped;
    xfcm_pkg::wide_t diff;
    xfcm_pkg::wide_t lim_pos;
    xfcm_pkg::wide_t lim_neg;
    xfcm_pkg::wide_t clamped;
    logic            moved;

    always_comb
    begin
        sum     = xfcm_pkg::wide_t'(angle_a) + xfcm_pkg::wide_t'(angle_b);
        // only the upper side wraps; low sums are left to the clamp
        wrapped = (sum > xfcm_pkg::HALF_TURN) ? sum - xfcm_pkg::FULL_TURN : sum;
        diff    = wrapped - xfcm_pkg::wide_t'(command);
        moved   = (diff > xfcm_pkg::DEADBAND) || (diff < -xfcm_pkg::DEADBAND);
        lim_pos = $signed({3'b000, limit});
        lim_neg = -lim_pos;
        clamped = wrapped;
        if (clamped > lim_pos)
        begin
            clamped = lim_pos;
        end
        if (clamped < lim_neg)
        begin
            clamped = lim_neg;
        end
        next_command = moved ? clamped[15:0] : command;
    end

endmodule

>>> rtl/xtail_fin_command_mixer.sv
// X-tail fin command mixer.
// An accepted beat passes the input register, then one combinational pass
// into the result register. Throughput: one beat per cycle while the output
// is empty or result_ready is high; fin commands feed back through cmd_reg.
// Reset (rst_n low, asynchronous): both stages empty, held angles and fin
// commands zero, safety disabled, homes zero, limits 18000.
module xtail_fin_command_mixer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  xfcm_pkg::in_t        item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output xfcm_pkg::out_t       result,
    input  logic                 cfg_we,
    input  xfcm_pkg::cfg_index_t cfg_index,
    input  logic [xfcm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned N = xfcm_pkg::FIN_COUNT;

    logic             s1_valid_reg;
    xfcm_pkg::in_t    s1_item_reg;
    logic             result_valid_reg;
    xfcm_pkg::out_t   result_reg;

    xfcm_pkg::angle_t held_reg [N];
    xfcm_pkg::angle_t held_next [N];
    xfcm_pkg::angle_t cmd_reg [N];
    xfcm_pkg::angle_t cmd_next [N];
    logic             safety_reg;
    logic             safety_next;
    xfcm_pkg::angle_t home_reg [N];
    xfcm_pkg::limit_t limit_reg [N];

    xfcm_pkg::angle_t lane_a [N];
    xfcm_pkg::angle_t lane_b [N];
    xfcm_pkg::angle_t lane_cmd [N];
    logic             sel_error;
    logic [1:0]       sel_idx;
    logic             advance;
    logic             fire;

    assign advance    = !result_valid_reg || result_ready;
    assign fire       = s1_valid_reg && advance;
    assign item_ready = !s1_valid_reg || advance;

    // held angles: 0 top, 1 starboard, 2 bottom, 3 port
    assign lane_a[0] = held_next[0];
    assign lane_b[0] = held_next[1];
    assign lane_a[1] = held_next[2];
    assign lane_b[1] = held_next[1];
    assign lane_a[2] = held_next[2];
    assign lane_b[2] = held_next[3];
    assign lane_a[3] = held_next[0];
    assign lane_b[3] = held_next[3];

    for (genvar g = 0; g < N; g++)
    begin : g_lane
        xfcm_fin_lane u_lane (
            .angle_a      (lane_a[g]),
            .angle_b      (lane_b[g]),
            .command      (cmd_reg[g]),
            .limit        (limit_reg[g]),
            .next_command (lane_cmd[g])
        );
    end

    assign sel_idx = 2'(s1_item_reg.fin_select - 3'd1);

    // held angle load, kept apart from the command update that reads the lanes
    always_comb
    begin
        held_next = held_reg;
        if (s1_item_reg.command == xfcm_pkg::CMD_FINS && safety_reg)
        begin
            if (s1_item_reg.angle_valid[0])
            begin
                held_next[0] = s1_item_reg.req_top;
            end
            if (s1_item_reg.angle_valid[1])
            begin
                held_next[1] = s1_item_reg.req_stbd;
            end
            if (s1_item_reg.angle_valid[2])
            begin
                held_next[2] = s1_item_reg.req_bottom;
            end
            if (s1_item_reg.angle_valid[3])
            begin
                held_next[3] = s1_item_reg.req_port;
            end
        end
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        safety_next = safety_reg;
        sel_error   = 1'b0;
        case (s1_item_reg.command)
            xfcm_pkg::CMD_FINS:
            begin
                if (safety_reg)
                begin
                    cmd_next = lane_cmd;
                end
            end
            xfcm_pkg::CMD_SAFETY:
            begin
                safety_next = s1_item_reg.enable_flag;
            end
            xfcm_pkg::CMD_TIMEOUT:
            begin
                if (safety_reg)
                begin
                    cmd_next = home_reg;
                end
            end
            xfcm_pkg::CMD_RESET:
            begin
                cmd_next = home_reg;
            end
            xfcm_pkg::CMD_DIRECT:
            begin
                if (s1_item_reg.fin_select == 3'd0)
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        cmd_next[i] = s1_item_reg.position;
                    end
                end
                else if (s1_item_reg.fin_select inside {[3'd1:3'd4]})
                begin
                    cmd_next[sel_idx] = s1_item_reg.position;
                end
                else
                begin
                    sel_error = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= item;
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            safety_reg       <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                held_reg[i] <= '0;
                cmd_reg[i]  <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                result_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                held_reg   <= held_next;
                cmd_reg    <= cmd_next;
                safety_reg <= safety_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg.fin1_command <= cmd_next[0];
            result_reg.fin2_command <= cmd_next[1];
            result_reg.fin3_command <= cmd_next[2];
            result_reg.fin4_command <= cmd_next[3];
            result_reg.select_error <= sel_error;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                home_reg[i]  <= '0;
                limit_reg[i] <= xfcm_pkg::LIMIT_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xfcm_pkg::REG_HOME_FIN1:  home_reg[0]  <= cfg_data;
                xfcm_pkg::REG_HOME_FIN2:  home_reg[1]  <= cfg_data;
                xfcm_pkg::REG_HOME_FIN3:  home_reg[2]  <= cfg_data;
                xfcm_pkg::REG_HOME_FIN4:  home_reg[3]  <= cfg_data;
                xfcm_pkg::REG_LIMIT_FIN1: limit_reg[0] <= cfg_data[14:0];
                xfcm_pkg::REG_LIMIT_FIN2: limit_reg[1] <= cfg_data[14:0];
                xfcm_pkg::REG_LIMIT_FIN3: limit_reg[2] <= cfg_data[14:0];
                xfcm_pkg::REG_LIMIT_FIN4: limit_reg[3] <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/xfcm_checker.sv
`include "assert_macros.svh"

module xfcm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           item_ready,
    input logic           result_valid,
    input logic           result_ready,
    input xfcm_pkg::out_t result
);

    // commands of the last delivered beat; zero out of reset
    xfcm_pkg::out_t prev_reg;
    logic           same_cmds;
    logic           out_beat;

    assign out_beat  = result_valid && result_ready;
    assign same_cmds = (result.fin1_command == prev_reg.fin1_command)
                    && (result.fin2_command == prev_reg.fin2_command)
                    && (result.fin3_command == prev_reg.fin3_command)
                    && (result.fin4_command == prev_reg.fin4_command);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (out_beat)
        begin
            prev_reg <= result;
        end
    end

    `XFCM_ASSERT(a_stall_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")
    `XFCM_ASSERT(a_empty_ready, clk, rst_n, !result_valid |-> item_ready, "input stalled with empty output")
    `XFCM_ASSERT(a_bad_select_keeps, clk, rst_n, result_valid && result.select_error |-> same_cmds, "select error changed a fin command")
    // the edge after one with reset low must show an empty output
    `XFCM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !result_valid, "result valid after reset")

endmodule

bind xtail_fin_command_mixer xfcm_checker u_xfcm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
